// ===== rtl/bcc_pkg.sv =====
// Shared constants for the box and circle contact test.
package bcc_pkg;

	localparam int COORD_BITS_DEF = 32;
	localparam int FRAC_BITS_DEF  = 16;

endpackage

// ===== rtl/box_circle_collision.sv =====
// Top level of the box and circle contact test.
//
// One request on the slave side carries one box (centre, half extents) and
// one circle (centre, radius) in signed fixed point; every request gives
// exactly one result on the master side. m_tuser holds the hit flag, m_tdata
// the depth, the unit normal and the contact point.
// The pipeline takes a new request in every cycle while the output moves.
// The pipeline has three front stages (clamp, squares, compare), one stage
// per root bit of the square root, FRAC_BITS + 1 divider stages for the
// normal, one multiply stage and the output register.
// When the receiver holds m_tready low with a result waiting, the whole
// pipeline freezes and s_tready drops in the same cycle; nothing is lost or
// repeated. Reset clears every valid bit, so the block comes up empty and
// ready.
module box_circle_collision import bcc_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF,
	localparam int IN_W  = 7 * COORD_BITS - 3,
	localparam int IN_DW = ((IN_W + 7) / 8) * 8,
	localparam int OUT_W  = 3 * COORD_BITS + 2 * FRAC_BITS + 3,
	localparam int OUT_DW = ((OUT_W + 7) / 8) * 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	// box_center_x, box_center_y, box_half_x, box_half_y,
	// circle_center_x, circle_center_y, circle_radius
	input  logic [IN_DW-1:0]  s_tdata,
	output logic              m_tvalid,
	input  logic              m_tready,
	// depth, normal_x, normal_y, contact_x, contact_y
	output logic [OUT_DW-1:0] m_tdata,
	// hit
	output logic              m_tuser
);

	localparam int C  = COORD_BITS;
	localparam int F  = FRAC_BITS;
	localparam int MW = C - 1;
	localparam int NW = F + 2;
	localparam int SQ_SBW  = 3 + 3 * MW + 2 * C;
	localparam int DIV_SBW = 3 + MW + 2 * C;

	logic en;

	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	// front
	logic          f_v, f_hit, f_sx, f_sy;
	logic [MW-1:0] f_ax, f_ay, f_rad;
	logic [C-1:0]  f_px, f_py;
	logic [2*MW-1:0] f_d2;

	bcc_front #(.COORD_BITS(C)) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_v    (s_tvalid),
		.bx      (s_tdata[C-1:0]),
		.by      (s_tdata[2*C-1:C]),
		.hx      (s_tdata[3*C-2:2*C]),
		.hy      (s_tdata[4*C-3:3*C-1]),
		.cx      (s_tdata[5*C-3:4*C-2]),
		.cy      (s_tdata[6*C-3:5*C-2]),
		.rad     (s_tdata[7*C-4:6*C-2]),
		.out_v   (f_v),
		.out_hit (f_hit),
		.out_sx  (f_sx),
		.out_sy  (f_sy),
		.out_ax  (f_ax),
		.out_ay  (f_ay),
		.out_rad (f_rad),
		.out_px  (f_px),
		.out_py  (f_py),
		.out_d2  (f_d2)
	);

	// square root
	logic              q_v;
	logic [MW-1:0]     q_dist;
	logic [SQ_SBW-1:0] q_sb;
	logic              q_hit, q_sx, q_sy;
	logic [MW-1:0]     q_ax, q_ay, q_rad;
	logic [C-1:0]      q_px, q_py;

	bcc_sqrt #(.RB(MW), .SBW(SQ_SBW)) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_v     (f_v),
		.in_rad   (f_d2),
		.in_sb    ({f_hit, f_sx, f_sy, f_ax, f_ay, f_rad, f_px, f_py}),
		.out_v    (q_v),
		.out_root (q_dist),
		.out_sb   (q_sb)
	);

	assign {q_hit, q_sx, q_sy, q_ax, q_ay, q_rad, q_px, q_py} = q_sb;

	// normal divider
	logic               d_v;
	logic [F:0]         d_ux, d_uy;
	logic [MW-1:0]      d_dist;
	logic [DIV_SBW-1:0] d_sb;
	logic               d_hit, d_sx, d_sy;
	logic [MW-1:0]      d_rad;
	logic [C-1:0]       d_px, d_py;

	bcc_div #(.MW(MW), .FRAC_BITS(F), .SBW(DIV_SBW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_v     (q_v),
		.mag_x    (q_ax),
		.mag_y    (q_ay),
		.divisor  (q_dist),
		.in_sb    ({q_hit, q_sx, q_sy, q_rad, q_px, q_py}),
		.out_v    (d_v),
		.quo_x    (d_ux),
		.quo_y    (d_uy),
		.out_dist (d_dist),
		.out_sb   (d_sb)
	);

	assign {d_hit, d_sx, d_sy, d_rad, d_px, d_py} = d_sb;

	// scale stage
	logic            v_s1, hit_s1, sx_s1, sy_s1, zero_s1;
	logic [F:0]      ux_s1, uy_s1;
	logic [MW-1:0]   depth_s1;
	logic [C-1:0]    px_s1, py_s1;
	logic [F+MW:0]   mx_s1, my_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			m_tvalid <= 1'b0;
		end else if (en) begin
			v_s1     <= d_v;
			m_tvalid <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit_s1   <= d_hit;
			sx_s1    <= d_sx;
			sy_s1    <= d_sy;
			zero_s1  <= d_dist == '0;
			ux_s1    <= d_ux;
			uy_s1    <= d_uy;
			depth_s1 <= d_rad - d_dist;
			px_s1    <= d_px;
			py_s1    <= d_py;
			mx_s1    <= (F+MW+1)'(d_ux) * (F+MW+1)'(d_dist);
			my_s1    <= (F+MW+1)'(d_uy) * (F+MW+1)'(d_dist);
		end
	end

	// output stage
	logic [C-1:0]  scx, scy, kx, ky;
	logic [NW-1:0] nx, ny;
	logic [MW-1:0] depth;
	logic          hit;

	always_comb begin
		scx = C'(mx_s1[F+MW:F]);
		scy = C'(my_s1[F+MW:F]);
		hit = hit_s1;
		if (!hit_s1) begin
			depth = '0;
			nx    = '0;
			ny    = '0;
			kx    = px_s1;
			ky    = py_s1;
		end else if (zero_s1) begin
			depth = depth_s1;
			nx    = NW'(1) << F;
			ny    = '0;
			kx    = px_s1;
			ky    = py_s1;
		end else begin
			depth = depth_s1;
			nx    = sx_s1 ? NW'(-NW'(ux_s1)) : NW'(ux_s1);
			ny    = sy_s1 ? NW'(-NW'(uy_s1)) : NW'(uy_s1);
			kx    = sx_s1 ? px_s1 - scx : px_s1 + scx;
			ky    = sy_s1 ? py_s1 - scy : py_s1 + scy;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_tuser <= hit;
			m_tdata <= OUT_DW'({ky, kx, ny, nx, depth});
		end
	end

endmodule

// ===== rtl/bcc_front.sv =====
// Front stages: clamp onto the box, squares and the hit compare.
module bcc_front import bcc_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    in_v,
	input  logic [COORD_BITS-1:0]   bx,
	input  logic [COORD_BITS-1:0]   by,
	input  logic [COORD_BITS-2:0]   hx,
	input  logic [COORD_BITS-2:0]   hy,
	input  logic [COORD_BITS-1:0]   cx,
	input  logic [COORD_BITS-1:0]   cy,
	input  logic [COORD_BITS-2:0]   rad,
	output logic                    out_v,
	output logic                    out_hit,
	output logic                    out_sx,
	output logic                    out_sy,
	output logic [COORD_BITS-2:0]   out_ax,
	output logic [COORD_BITS-2:0]   out_ay,
	output logic [COORD_BITS-2:0]   out_rad,
	output logic [COORD_BITS-1:0]   out_px,
	output logic [COORD_BITS-1:0]   out_py,
	output logic [2*COORD_BITS-3:0] out_d2
);

	localparam int C  = COORD_BITS;
	localparam int MW = C - 1;
	localparam int PW = 2 * MW;

	logic signed [C:0]   lox, hix, loy, hiy, cxe, cye, px, py;
	logic signed [C+1:0] dx, dy;
	logic        [C+1:0] ax, ay;
	logic                near;

	always_comb begin
		cxe = $signed({cx[C-1], cx});
		cye = $signed({cy[C-1], cy});
		lox = $signed({bx[C-1], bx}) - $signed({2'b00, hx});
		hix = $signed({bx[C-1], bx}) + $signed({2'b00, hx});
		loy = $signed({by[C-1], by}) - $signed({2'b00, hy});
		hiy = $signed({by[C-1], by}) + $signed({2'b00, hy});
		if (cxe < lox) begin
			px = lox;
		end else if (cxe > hix) begin
			px = hix;
		end else begin
			px = cxe;
		end
		if (cye < loy) begin
			py = loy;
		end else if (cye > hiy) begin
			py = hiy;
		end else begin
			py = cye;
		end
		dx = $signed({cxe[C], cxe}) - $signed({px[C], px});
		dy = $signed({cye[C], cye}) - $signed({py[C], py});
		ax = dx[C+1] ? (C+2)'(-dx) : (C+2)'(dx);
		ay = dy[C+1] ? (C+2)'(-dy) : (C+2)'(dy);
		near = (ax <= {3'b000, rad}) && (ay <= {3'b000, rad});
	end

	logic          v_s1, near_s1, sx_s1, sy_s1;
	logic [MW-1:0] ax_s1, ay_s1, rad_s1;
	logic [C-1:0]  px_s1, py_s1;

	logic          v_s2, near_s2, sx_s2, sy_s2;
	logic [MW-1:0] ax_s2, ay_s2, rad_s2;
	logic [C-1:0]  px_s2, py_s2;
	logic [PW-1:0] axx_s2, ayy_s2, rr_s2;

	logic [PW:0]   d2;

	assign d2 = {1'b0, axx_s2} + {1'b0, ayy_s2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			out_v <= 1'b0;
		end else if (en) begin
			v_s1  <= in_v;
			v_s2  <= v_s1;
			out_v <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			near_s1 <= near;
			sx_s1   <= dx[C+1];
			sy_s1   <= dy[C+1];
			ax_s1   <= ax[MW-1:0];
			ay_s1   <= ay[MW-1:0];
			rad_s1  <= rad;
			px_s1   <= px[C-1:0];
			py_s1   <= py[C-1:0];

			near_s2 <= near_s1;
			sx_s2   <= sx_s1;
			sy_s2   <= sy_s1;
			ax_s2   <= ax_s1;
			ay_s2   <= ay_s1;
			rad_s2  <= rad_s1;
			px_s2   <= px_s1;
			py_s2   <= py_s1;
			axx_s2  <= PW'(ax_s1) * PW'(ax_s1);
			ayy_s2  <= PW'(ay_s1) * PW'(ay_s1);
			rr_s2   <= PW'(rad_s1) * PW'(rad_s1);

			out_hit <= near_s2 && (d2 <= {1'b0, rr_s2});
			out_sx  <= sx_s2;
			out_sy  <= sy_s2;
			out_ax  <= ax_s2;
			out_ay  <= ay_s2;
			out_rad <= rad_s2;
			out_px  <= px_s2;
			out_py  <= py_s2;
			out_d2  <= d2[PW-1:0];
		end
	end

endmodule

// ===== rtl/bcc_sqrt.sv =====
// Pipelined integer square root, one result bit per stage.
module bcc_sqrt import bcc_pkg::*; #(
	parameter int RB  = COORD_BITS_DEF - 1,
	parameter int SBW = 1
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_v,
	input  logic [2*RB-1:0] in_rad,
	input  logic [SBW-1:0]  in_sb,
	output logic            out_v,
	output logic [RB-1:0]   out_root,
	output logic [SBW-1:0]  out_sb
);

	localparam int RW = 2 * RB;

	logic [RW-1:0]  rem_sn  [0:RB];
	logic [RB-1:0]  root_sn [0:RB];
	logic [SBW-1:0] sb_sn   [0:RB];
	logic           v_sn    [0:RB];

	assign rem_sn[0]  = in_rad;
	assign root_sn[0] = '0;
	assign sb_sn[0]   = in_sb;
	assign v_sn[0]    = in_v;

	for (genvar i = 0; i < RB; i++) begin : g_stage
		localparam int B = RB - 1 - i;
		logic [RW-1:0] trial;

		always_comb begin
			trial = (RW'(root_sn[i]) << (B + 1)) + (RW'(1) << (2 * B));
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_sn[i+1] <= 1'b0;
			end else if (en) begin
				v_sn[i+1] <= v_sn[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sb_sn[i+1] <= sb_sn[i];
				if (rem_sn[i] >= trial) begin
					rem_sn[i+1]  <= rem_sn[i] - trial;
					root_sn[i+1] <= root_sn[i] | (RB'(1) << B);
				end else begin
					rem_sn[i+1]  <= rem_sn[i];
					root_sn[i+1] <= root_sn[i];
				end
			end
		end
	end

	assign out_v    = v_sn[RB];
	assign out_root = root_sn[RB];
	assign out_sb   = sb_sn[RB];

endmodule

// ===== rtl/bcc_div.sv =====
// Pipelined two-lane divider for the unit normal, one quotient bit per stage.
module bcc_div import bcc_pkg::*; #(
	parameter int MW        = COORD_BITS_DEF - 1,
	parameter int FRAC_BITS = FRAC_BITS_DEF,
	parameter int SBW       = 1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_v,
	input  logic [MW-1:0]      mag_x,
	input  logic [MW-1:0]      mag_y,
	input  logic [MW-1:0]      divisor,
	input  logic [SBW-1:0]     in_sb,
	output logic               out_v,
	output logic [FRAC_BITS:0] quo_x,
	output logic [FRAC_BITS:0] quo_y,
	output logic [MW-1:0]      out_dist,
	output logic [SBW-1:0]     out_sb
);

	localparam int F = FRAC_BITS;

	logic [MW-1:0]  remx_sn [0:F];
	logic [MW-1:0]  remy_sn [0:F];
	logic [F:0]     qx_sn   [0:F];
	logic [F:0]     qy_sn   [0:F];
	logic [MW-1:0]  dist_sn [0:F];
	logic [SBW-1:0] sb_sn   [0:F];
	logic           v_sn    [0:F];

	logic gex, gey;

	assign gex = mag_x >= divisor;
	assign gey = mag_y >= divisor;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sn[0] <= 1'b0;
		end else if (en) begin
			v_sn[0] <= in_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			qx_sn[0]   <= {{F{1'b0}}, gex};
			qy_sn[0]   <= {{F{1'b0}}, gey};
			remx_sn[0] <= gex ? mag_x - divisor : mag_x;
			remy_sn[0] <= gey ? mag_y - divisor : mag_y;
			dist_sn[0] <= divisor;
			sb_sn[0]   <= in_sb;
		end
	end

	for (genvar i = 1; i <= F; i++) begin : g_stage
		logic [MW:0] r2x, r2y;
		logic        tx, ty;

		always_comb begin
			r2x = {remx_sn[i-1], 1'b0};
			r2y = {remy_sn[i-1], 1'b0};
			tx  = r2x >= {1'b0, dist_sn[i-1]};
			ty  = r2y >= {1'b0, dist_sn[i-1]};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_sn[i] <= 1'b0;
			end else if (en) begin
				v_sn[i] <= v_sn[i-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				remx_sn[i] <= tx ? MW'(r2x - {1'b0, dist_sn[i-1]}) : MW'(r2x);
				remy_sn[i] <= ty ? MW'(r2y - {1'b0, dist_sn[i-1]}) : MW'(r2y);
				qx_sn[i]   <= {qx_sn[i-1][F-1:0], tx};
				qy_sn[i]   <= {qy_sn[i-1][F-1:0], ty};
				dist_sn[i] <= dist_sn[i-1];
				sb_sn[i]   <= sb_sn[i-1];
			end
		end
	end

	assign out_v    = v_sn[F];
	assign quo_x    = qx_sn[F];
	assign quo_y    = qy_sn[F];
	assign out_dist = dist_sn[F];
	assign out_sb   = sb_sn[F];

endmodule
